// File: design/pinterp_pkg.sv
// shared types, constants and coefficient table for the 2x polyphase interpolator
// no dependencies
package pinterp_pkg;

   // field and datapath widths
   localparam int SAMPLE_W  = 16;
   localparam int COEF_FRAC = 16;
   localparam int COEF_W    = 18;
   localparam int DIGIT_W   = 8;
   localparam int PROD_W    = COEF_W + DIGIT_W + 1;
   localparam int ACC_W     = 40;
   localparam int RND_W     = ACC_W - COEF_FRAC;

   // polyphase geometry: 24 even taps, center tap on the odd phase
   localparam int TAP_COUNT    = 47;
   localparam int HIST_DEPTH   = (TAP_COUNT + 1) / 2;
   localparam int CENTER_DELAY = (TAP_COUNT - 3) / 4;
   localparam int TAP_IDX_W    = $clog2(HIST_DEPTH + 2);

   localparam logic [TAP_IDX_W-1:0] FIRST_TAP    = '0;
   localparam logic [TAP_IDX_W-1:0] LAST_EVEN    = TAP_IDX_W'(HIST_DEPTH - 1);
   localparam logic [TAP_IDX_W-1:0] CENTER_TAP   = TAP_IDX_W'(HIST_DEPTH);
   localparam logic [TAP_IDX_W-1:0] DONE_TAP     = TAP_IDX_W'(HIST_DEPTH + 1);
   localparam logic [TAP_IDX_W-1:0] CAPTURE_TAP  = TAP_IDX_W'(CENTER_DELAY);

   // control toward the delay line
   typedef struct packed {
      logic load;      // shift a new sample in at the head
      logic rotate;    // circular step, head moves to the tail
      logic capture;   // keep the head as the center-tap sample
   } hist_ctrl_type;

   // control toward the digit-serial multiply-accumulate
   typedef struct packed {
      logic clear;     // zero the accumulator
      logic acc_en;    // add one digit product
      logic digit_hi;  // upper (signed) digit of the operand
      logic take_abs;  // latch magnitude and sign for rounding
   } mac_ctrl_type;

   // signed Q2.16 taps; even phase at 0..23, center tap at 24
   function automatic logic signed [COEF_W-1:0] coef_lookup(
      input logic [TAP_IDX_W-1:0] idx);
      logic signed [COEF_W-1:0] c;
      case (idx)
         5'd0:    c = -18'sd145;
         5'd1:    c = 18'sd193;
         5'd2:    c = -18'sd323;
         5'd3:    c = 18'sd555;
         5'd4:    c = -18'sd914;
         5'd5:    c = 18'sd1434;
         5'd6:    c = -18'sd2170;
         5'd7:    c = 18'sd3221;
         5'd8:    c = -18'sd4805;
         5'd9:    c = 18'sd7491;
         5'd10:   c = -18'sd13392;
         5'd11:   c = 18'sd41587;
         5'd12:   c = 18'sd41587;
         5'd13:   c = -18'sd13392;
         5'd14:   c = 18'sd7491;
         5'd15:   c = -18'sd4805;
         5'd16:   c = 18'sd3221;
         5'd17:   c = -18'sd2170;
         5'd18:   c = 18'sd1434;
         5'd19:   c = -18'sd914;
         5'd20:   c = 18'sd555;
         5'd21:   c = -18'sd323;
         5'd22:   c = 18'sd193;
         5'd23:   c = -18'sd145;
         5'd24:   c = 18'sd65606;
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

// File: design/pinterp_hist.sv
// rotating input delay line with center-tap capture
// depends on pinterp_pkg
module pinterp_hist
   import pinterp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  hist_ctrl_type              ctrl,
   input  logic signed [SAMPLE_W-1:0] sample_in,
   output logic signed [SAMPLE_W-1:0] head,
   output logic signed [SAMPLE_W-1:0] center
);

   logic signed [SAMPLE_W-1:0] hist_ff [HIST_DEPTH];
   logic signed [SAMPLE_W-1:0] hist_in [HIST_DEPTH];
   logic signed [SAMPLE_W-1:0] center_ff;

   // next contents: push at head, or rotate head to tail
   always_comb begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
         hist_in[i] = hist_ff[i];
      end
      if (ctrl.load) begin
         hist_in[0] = sample_in;
         for (int i = 1; i < HIST_DEPTH; i++) begin
            hist_in[i] = hist_ff[i-1];
         end
      end else if (ctrl.rotate) begin
         for (int i = 0; i < HIST_DEPTH - 1; i++) begin
            hist_in[i] = hist_ff[i+1];
         end
         hist_in[HIST_DEPTH-1] = hist_ff[0];
      end
   end

   // delay line, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_ff[i] <= hist_in[i];
         end
      end
   end

   // center-tap sample for the odd phase
   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         center_ff <= hist_ff[0];
      end
   end

   assign head   = hist_ff[0];
   assign center = center_ff;

endmodule

// File: design/pinterp_mac.sv
// digit-serial multiply-accumulate, byte digits, with round and saturate
// depends on pinterp_pkg
module pinterp_mac
   import pinterp_pkg::*;
(
   input  logic                       clock,
   input  mac_ctrl_type               ctrl,
   input  logic signed [SAMPLE_W-1:0] operand,
   input  logic signed [COEF_W-1:0]   coef,
   output logic signed [SAMPLE_W-1:0] result
);

   logic signed [DIGIT_W:0]  digit;
   logic signed [PROD_W-1:0] product;
   logic signed [ACC_W-1:0]  prod_ext;
   logic signed [ACC_W-1:0]  addend;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic [ACC_W-1:0]         mag_ff;
   logic                     neg_ff;
   logic [ACC_W-1:0]         mag_rnd;
   logic [RND_W-1:0]         rnd;

   // low digit is unsigned, high digit carries the sign
   assign digit = ctrl.digit_hi ? {operand[SAMPLE_W-1], operand[SAMPLE_W-1:DIGIT_W]}
                                : {1'b0, operand[DIGIT_W-1:0]};

   assign product  = coef * digit;
   assign prod_ext = {{(ACC_W-PROD_W){product[PROD_W-1]}}, product};
   assign addend   = ctrl.digit_hi ? (prod_ext <<< DIGIT_W) : prod_ext;

   // accumulator
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (ctrl.acc_en) begin
         acc_in = acc_ff + addend;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // magnitude and sign for round half away from zero
   always_ff @(posedge clock) begin
      if (ctrl.take_abs) begin
         neg_ff <= acc_ff[ACC_W-1];
         mag_ff <= acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
      end
   end

   assign mag_rnd = mag_ff + (ACC_W'(1) << (COEF_FRAC - 1));
   assign rnd     = mag_rnd[ACC_W-1:COEF_FRAC];

   // saturate to the 16-bit range
   always_comb begin
      if (neg_ff) begin
         if (rnd > RND_W'(32768)) begin
            result = 16'sh8000;
         end else begin
            result = SAMPLE_W'(-$signed(rnd[SAMPLE_W-1:0]));
         end
      end else begin
         if (rnd > RND_W'(32767)) begin
            result = 16'sh7fff;
         end else begin
            result = $signed(rnd[SAMPLE_W-1:0]);
         end
      end
   end

endmodule

// File: design/polyphase_2x_interpolator_fir.sv
// 2x polyphase FIR interpolator, top level: sequencer and result register
// per input: the 24 even taps, each as a low and a high byte digit, then rounding and the even beat;
// then the center tap, as two byte digits, rounding and the odd beat; req_stall stays high until
// the odd beat is in the result register, so no new input is taken before then
// reset (synchronous, active high) clears the delay line, sequencer and result valid
module polyphase_2x_interpolator_fir
   import pinterp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   output logic                       rsp_second_of_pair
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MAC  = 2'd1;
   localparam logic [1:0] ST_ABS  = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]                 state_ff, state_in;
   logic [TAP_IDX_W-1:0]       tap_ff, tap_in;
   logic                       phase_ff, phase_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;
   logic                       rsp_second_ff;
   logic                       accept;
   logic                       out_free;
   logic                       emit;
   logic                       second;
   hist_ctrl_type              hctrl;
   mac_ctrl_type               mctrl;
   logic signed [SAMPLE_W-1:0] head;
   logic signed [SAMPLE_W-1:0] center;
   logic signed [SAMPLE_W-1:0] operand;
   logic signed [SAMPLE_W-1:0] result;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign second    = (tap_ff == DONE_TAP);
   assign emit      = (state_ff == ST_EMIT) && out_free;
   assign operand   = (tap_ff == CENTER_TAP) ? center : head;

   // sequencer
   always_comb begin
      state_in = state_ff;
      tap_in   = tap_ff;
      phase_in = phase_ff;
      hctrl    = '0;
      mctrl    = '0;
      mctrl.digit_hi = phase_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               hctrl.load  = 1'b1;
               mctrl.clear = 1'b1;
               tap_in      = FIRST_TAP;
               phase_in    = 1'b0;
               state_in    = ST_MAC;
            end
         end
         ST_MAC: begin
            mctrl.acc_en = 1'b1;
            phase_in     = !phase_ff;
            if (phase_ff) begin
               tap_in = tap_ff + 1'b1;
               if (tap_ff != CENTER_TAP) begin
                  hctrl.rotate = 1'b1;
               end
               if (tap_ff == CAPTURE_TAP) begin
                  hctrl.capture = 1'b1;
               end
               if (tap_ff == LAST_EVEN || tap_ff == CENTER_TAP) begin
                  state_in = ST_ABS;
               end
            end
         end
         ST_ABS: begin
            mctrl.take_abs = 1'b1;
            state_in       = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               if (second) begin
                  state_in = ST_IDLE;
               end else begin
                  mctrl.clear = 1'b1;
                  phase_in    = 1'b0;
                  state_in    = ST_MAC;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tap_ff   <= FIRST_TAP;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
         phase_ff <= phase_in;
      end
   end

   // result register, holds a beat while stalled
   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_sample_ff <= result;
         rsp_second_ff <= second;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sample_out     = rsp_sample_ff;
   assign rsp_second_of_pair = rsp_second_ff;

   pinterp_hist u_hist (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (hctrl),
      .sample_in (req_sample_in),
      .head      (head),
      .center    (center)
   );

   pinterp_mac u_mac (
      .clock   (clock),
      .ctrl    (mctrl),
      .operand (operand),
      .coef    (coef_lookup(tap_ff)),
      .result  (result)
   );

endmodule

// File: dv/polyphase_2x_interpolator_fir_checker.sv
// output checker for the 2x polyphase interpolator: predicts each pair of output beats
// from its own copy of the delay line and compares them in order
// depends on pinterp_pkg for the sample width, the coefficient fraction width and the center delay
`timescale 1ns / 1ps

module polyphase_2x_interpolator_fir_checker
   import pinterp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic signed [SAMPLE_W-1:0] rsp_sample_out,
   input  logic                       rsp_second_of_pair,
   output int                         mismatch_count,
   output int                         beats_checked,
   output int                         beats_pending,
   output int                         clip_count
);
   localparam int SW        = SAMPLE_W;
   localparam int FRAC      = COEF_FRAC;
   localparam int DEPTH     = 24;
   localparam int ODD_DELAY = CENTER_DELAY;
   localparam int ODD_TAP_Q16 = 65606;
   localparam int REPORT_MAX  = 10;

   typedef struct packed {
      logic signed [SW-1:0] sample;
      logic                 second;
   } out_beat_type;

   // even-phase taps, signed Q2.16, index 0 multiplies the newest sample
   int even_tap [DEPTH];
   logic signed [SW-1:0] delay_line [DEPTH];
   out_beat_type expected_q [$];

   initial begin
      even_tap = '{-145, 193, -323, 555, -914, 1434, -2170, 3221,
                   -4805, 7491, -13392, 41587, 41587, -13392, 7491, -4805,
                   3221, -2170, 1434, -914, 555, -323, 193, -145};
      mismatch_count = 0;
      beats_checked  = 0;
      clip_count     = 0;
   end

   assign beats_pending = expected_q.size();

   // round half away from zero at the binary point, then clip to 16 bits
   function automatic logic signed [SW-1:0] round_to_sample(input longint acc,
                                                            output bit clipped);
      longint mag;
      longint res;
      mag = (acc < 0) ? -acc : acc;
      mag = (mag + (longint'(1) << (FRAC - 1))) >> FRAC;
      clipped = 1'b0;
      if (acc < 0) begin
         if (mag > 32768) begin
            res = -32768;
            clipped = 1'b1;
         end else begin
            res = -mag;
         end
      end else begin
         if (mag > 32767) begin
            res = 32767;
            clipped = 1'b1;
         end else begin
            res = mag;
         end
      end
      return res[SW-1:0];
   endfunction

   always @(posedge clock) begin : watch
      longint       acc;
      bit           clipped;
      out_beat_type beat;
      out_beat_type want;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) delay_line[i] = '0;
         expected_q.delete();
      end else begin
         // input beat: shift the delay line and queue the even and odd results
         if (req_valid && !req_stall) begin
            for (int i = DEPTH - 1; i > 0; i--) delay_line[i] = delay_line[i-1];
            delay_line[0] = req_sample_in;
            acc = 0;
            for (int i = 0; i < DEPTH; i++)
               acc += longint'(even_tap[i]) * longint'(delay_line[i]);
            beat.sample = round_to_sample(acc, clipped);
            beat.second = 1'b0;
            if (clipped) clip_count++;
            expected_q.push_back(beat);
            acc = longint'(ODD_TAP_Q16) * longint'(delay_line[ODD_DELAY]);
            beat.sample = round_to_sample(acc, clipped);
            beat.second = 1'b1;
            if (clipped) clip_count++;
            expected_q.push_back(beat);
         end
         // output beat: compare with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("unexpected output beat %0d: sample %0d second %0b",
                           beats_checked, rsp_sample_out, rsp_second_of_pair);
            end else begin
               want = expected_q.pop_front();
               if (rsp_sample_out !== want.sample ||
                   rsp_second_of_pair !== want.second) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_MAX)
                     $display({"mismatch on output beat %0d: expected sample %0d ",
                               "second %0b, got sample %0d second %0b"},
                              beats_checked, $signed(want.sample), want.second,
                              rsp_sample_out, rsp_second_of_pair);
               end
            end
            beats_checked++;
         end
      end
   end

endmodule

// File: dv/polyphase_2x_interpolator_fir_test.sv
// testbench top for the 2x polyphase interpolator: clock, reset, input stimulus,
// output stall generation and the verdict
// depends on pinterp_pkg, polyphase_2x_interpolator_fir and the output checker
`timescale 1ns / 1ps

module polyphase_2x_interpolator_fir_test
   import pinterp_pkg::*;
();

   localparam int RANDOM_SAMPLES = 1700;
   localparam int DRAIN_CYCLES   = 64;
   localparam int CYCLE_LIMIT    = 600000;

   typedef enum int {
      MIX_UNIFORM,
      MIX_ALTERNATE,
      MIX_SMALL,
      MIX_COARSE,
      MIX_FULL_DC
   } stim_mix_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample_in = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic                       rsp_second_of_pair;

   int  mismatch_count;
   int  beats_checked;
   int  beats_pending;
   int  clip_count;
   int  samples_sent = 0;
   int  cycle_count = 0;
   int  stall_left = 0;
   bit  idle_en = 1'b0;

   always #6 clock = ~clock;

   polyphase_2x_interpolator_fir DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample_in      (req_sample_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sample_out     (rsp_sample_out),
      .rsp_second_of_pair (rsp_second_of_pair)
   );

   polyphase_2x_interpolator_fir_checker pair_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample_in      (req_sample_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sample_out     (rsp_sample_out),
      .rsp_second_of_pair (rsp_second_of_pair),
      .mismatch_count     (mismatch_count),
      .beats_checked      (beats_checked),
      .beats_pending      (beats_pending),
      .clip_count         (clip_count)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("polyphase_2x_interpolator_fir_test: FAIL");
         $finish;
      end
   end

   // output stalls: while idling is enabled, each accepted beat may be followed by a random stall
   always @(posedge clock) begin : stall_gen
      int draw;
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= (stall_left > 1);
      end else if (!reset && rsp_valid && !rsp_stall && idle_en) begin
         draw = $urandom_range(0, 6);
         stall_left <= draw;
         rsp_stall  <= (draw != 0);
      end
   end

   // one input beat, then an optional gap with valid low
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
      int gap;
      req_valid     <= 1'b1;
      req_sample_in <= value;
      do @(posedge clock); while (req_stall);
      samples_sent++;
      gap = idle_en ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold the input until every predicted output beat has been seen
   task automatic wait_for_outputs();
      req_valid <= 1'b0;
      while (beats_checked < 2 * samples_sent) @(posedge clock);
   endtask

   initial begin : stimulus
      stim_mix_type               mix;
      int                         run_len;
      bit                         flip;
      logic signed [SAMPLE_W-1:0] value;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // impulse of the most negative sample walks through every tap:
      // start-up from a cleared line and exact half ties on the even-phase taps with odd coefficients
      send_sample(16'sh8000);
      repeat (22) send_sample(16'sh0000);
      // full-scale step pair
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      wait_for_outputs();

      // random runs of one mix each, some with no idling at all
      while (samples_sent < RANDOM_SAMPLES + 25) begin
         run_len = $urandom_range(1, 40);
         mix     = stim_mix_type'($urandom_range(0, 4));
         idle_en = ($urandom_range(0, 3) != 0);
         flip    = $urandom_range(0, 1);
         for (int k = 0; k < run_len; k++) begin
            case (mix)
               MIX_UNIFORM:   value = SAMPLE_W'($urandom_range(0, 65535));
               MIX_ALTERNATE: value = ((k % 2) ^ flip) ? 16'sh7FFF : 16'sh8000;
               MIX_SMALL:     value = $signed(SAMPLE_W'($urandom_range(0, 15))) - 16'sd8;
               MIX_COARSE:    value = {2'($urandom_range(0, 3)), 14'b0};
               default:       value = flip ? 16'sh7FFF : 16'sh8000;
            endcase
            send_sample(value);
         end
         if ($urandom_range(0, 15) == 0) wait_for_outputs();
      end

      // drain, then watch a while for stray beats
      wait_for_outputs();
      idle_en = 1'b0;
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d input samples, checked %0d output beats (%0d clipped)",
               samples_sent, beats_checked, clip_count);
      $display("mixes: impulse walk, uniform, alternating and constant full scale, small, coarse");
      if (mismatch_count == 0 && beats_pending == 0) begin
         $display("polyphase_2x_interpolator_fir_test: PASS");
      end else begin
         $display("%0d mismatches, %0d beats still expected", mismatch_count, beats_pending);
         $display("polyphase_2x_interpolator_fir_test: FAIL");
      end
      $finish;
   end

endmodule
